// ===== rtl/plen_pkg.sv =====
package plen_pkg;

  // Default list depth, handed to the top level parameter.
  localparam int unsigned CAPACITY_DEF = 16;

  // Width of one stored value.
  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Command codes carried by the input channel.
  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_t;

  // Status codes carried by the result channel.
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  // What one cell of the chain does at the next clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_PREV,
    CELL_NEXT,
    CELL_HEAD
  } cell_act_t;

  // Control handed from the sequencer to one cell.
  typedef struct packed {
    cell_act_t act;
    data_t     load_value;
  } cell_ctl_t;

endpackage

// ===== rtl/plen_if.sv =====
// Command channel: one beat carries one list command.
interface plen_in_if;
  import plen_pkg::*;

  logic        valid;
  logic        ready;
  cmd_t        cmd;
  logic [7:0]  position;
  data_t       value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// Result channel: one beat carries one status or one displayed value.
interface plen_out_if;
  import plen_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  data_t       element;
  logic        last;

  modport source (output valid, output status, output element, output last, input ready);
  modport sink   (input valid, input status, input element, input last, output ready);
endinterface

// ===== rtl/positional_list_engine_unit.sv =====
// Channel   Port    Direction  Beat contents
// command   in_ch   in         cmd, position, value
// result    out_ch  out        status, element, last
//
// Append, insert and delete act on every cell in parallel, shifting where needed.
// Display of a non-empty list holds the input off while it streams the stored
// values, one beat each; an empty list answers with a single STAT_EMPTY beat.
// The chain rotates by one place per beat and ends in its original order.
// Reset (rst_n low, synchronous) empties the list and the result register.
// A command beat is taken whenever no display is running and the result
// register is empty or being drained in the same cycle.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = plen_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  plen_in_if.sink    in_ch,
  plen_out_if.source out_ch
);
  import plen_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = 9;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DISP = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] remain_r, remain_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  data_t         out_element_r, out_element_nxt;
  logic          out_last_r, out_last_nxt;

  data_t         cell_data [CAPACITY];
  cell_ctl_t     cell_ctl  [CAPACITY];

  logic          slot_free;
  logic          accept;
  logic          full;
  logic          empty;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] count_ext;
  logic [IW-1:0] pos_idx;
  logic [IW-1:0] rot_last;
  logic          do_append, do_insert, do_delete, do_rotate;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign pos_ext   = PW'(in_ch.position);
  assign count_ext = PW'(count_r);
  assign pos_idx   = IW'(in_ch.position - 8'd1);
  assign rot_last  = IW'(count_r - CW'(1));

  // Command decode, status and the sequencer.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    remain_nxt      = remain_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    do_append       = 1'b0;
    do_insert       = 1'b0;
    do_delete       = 1'b0;
    do_rotate       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_element_nxt = '0;
          out_last_nxt    = 1'b1;
          out_status_nxt  = STAT_OK;
          unique case (in_ch.cmd)
            CMD_APPEND: begin
              if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                do_append = 1'b1;
                count_nxt = CW'(count_r + CW'(1));
              end
              out_valid_nxt = 1'b1;
            end
            CMD_INSERT: begin
              if (pos_ext == '0 || pos_ext > count_ext + PW'(1)) begin
                out_status_nxt = STAT_BADPOS;
              end else if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                do_insert = 1'b1;
                count_nxt = CW'(count_r + CW'(1));
              end
              out_valid_nxt = 1'b1;
            end
            CMD_DELETE: begin
              if (empty) begin
                out_status_nxt = STAT_EMPTY;
              end else if (pos_ext == '0 || pos_ext > count_ext) begin
                out_status_nxt = STAT_BADPOS;
              end else begin
                do_delete = 1'b1;
                count_nxt = CW'(count_r - CW'(1));
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
              // Display: an empty list answers at once, otherwise stream.
              if (empty) begin
                out_status_nxt = STAT_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                remain_nxt = count_r;
                state_nxt  = S_DISP;
              end
            end
          endcase
        end
      end
      S_DISP: begin
        // Emit the head cell and rotate the chain by one place.
        if (slot_free) begin
          do_rotate       = 1'b1;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STAT_OK;
          out_element_nxt = cell_data[0];
          out_last_nxt    = (remain_r == CW'(1));
          remain_nxt      = CW'(remain_r - CW'(1));
          if (remain_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Per-cell action, each cell compared against its own index.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i].load_value = in_ch.value;
      cell_ctl[i].act        = CELL_HOLD;
      if (do_append && CW'(i) == count_r) begin
        cell_ctl[i].act = CELL_LOAD;
      end else if (do_insert && IW'(i) == pos_idx) begin
        cell_ctl[i].act = CELL_LOAD;
      end else if (do_insert && IW'(i) > pos_idx) begin
        cell_ctl[i].act = CELL_PREV;
      end else if (do_delete && IW'(i) >= pos_idx) begin
        cell_ctl[i].act = CELL_NEXT;
      end else if (do_rotate && IW'(i) == rot_last) begin
        cell_ctl[i].act = CELL_HEAD;
      end else if (do_rotate && IW'(i) < rot_last) begin
        cell_ctl[i].act = CELL_NEXT;
      end
    end
  end

  // The chain of cells; the ends see themselves as missing neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    plen_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[g]),
      .prev_data (cell_data[(g == 0) ? 0 : g - 1]),
      .next_data (cell_data[(g == CAPACITY - 1) ? g : g + 1]),
      .head_data (cell_data[0]),
      .data_o    (cell_data[g])
    );
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.element = out_element_r;
  assign out_ch.last    = out_last_r;

endmodule

// ===== rtl/plen_cell.sv =====
module plen_cell (
  input  logic                clk,
  input  plen_pkg::cell_ctl_t ctl,
  input  plen_pkg::data_t     prev_data,
  input  plen_pkg::data_t     next_data,
  input  plen_pkg::data_t     head_data,
  output plen_pkg::data_t     data_o
);
  import plen_pkg::*;

  data_t data_r;
  data_t data_nxt;

  // Pick the new content from the value bus or a neighbor.
  always_comb begin
    unique case (ctl.act)
      CELL_LOAD: data_nxt = ctl.load_value;
      CELL_PREV: data_nxt = prev_data;
      CELL_NEXT: data_nxt = next_data;
      CELL_HEAD: data_nxt = head_data;
      default:   data_nxt = data_r;
    endcase
  end

  // Stored entry; payload only, so no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ===== rtl/plen_checker.sv =====
module plen_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input plen_pkg::cmd_t     in_cmd,
  input logic               out_valid,
  input logic               out_ready,
  input plen_pkg::status_t  out_status,
  input plen_pkg::data_t    out_element,
  input logic               out_last
);
  import plen_pkg::*;

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_element)
      && $stable(out_last))
    else $error("stalled result beat changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Edit commands answer in the next cycle with a single closing beat.
  a_edit_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd != CMD_DISPLAY
      |=> out_valid && out_last && out_element == '0)
    else $error("edit command not answered by one closing beat");

  // Any error status ends the answer to its command.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_last)
    else $error("error status on a beat that is not the last");

endmodule

bind positional_list_engine_unit plen_checker u_plen_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_cmd      (in_ch.cmd),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_element (out_ch.element),
  .out_last    (out_ch.last)
);
